// ----- src/sbx_pkg.sv -----
// ============================================================================
// sbx_pkg: shared types, constants and functions
// Widths, register indexes, pipeline depth and the root constants of the
// fractional power-of-two unit used by the SBX gene crossover block.
// ============================================================================
`default_nettype none

package sbx_pkg;

    localparam int GENE_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int DRAW_W    = 16;
    localparam int BETA_W    = 32;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_DIST_INDEX = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CROSS_PROB = 8'd1;

    localparam logic [7:0]  DIST_INDEX_RESET = 8'd20;
    localparam logic [16:0] CROSS_PROB_RESET = 17'd32768;

    localparam logic [BETA_W-1:0] BETA_MAX = 32'h8000_0000;

    // Stage map of the spread unit: range reduction, 16 squarings, exponent,
    // 20 divide steps, fraction select, 16 root multiplies, beta scaling.
    localparam int LOG_STEPS = 16;
    localparam int DIV_STEPS = 20;
    localparam int POW_STEPS = 16;
    localparam int SPR_LAT   = 1 + LOG_STEPS + 1 + DIV_STEPS + 1 + POW_STEPS + 1;

    typedef logic signed [GENE_W-1:0] gene_t;

    typedef struct packed {
        gene_t a;
        gene_t b;
        gene_t lo;
        gene_t hi;
        logic  crossed;
    } gene_side_t;

    typedef struct packed {
        logic       neg;
        logic       zero;
        gene_side_t side;
    } spr_ctl_t;

    function automatic logic [63:0] sbx_isqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] bit_m;
        logic [63:0] x;
        r     = 64'd0;
        bit_m = 64'd1 << 62;
        x     = v;
        for (int i = 0; i < 32; i++) begin
            if (x >= r + bit_m) begin
                x = x - (r + bit_m);
                r = (r >> 1) + bit_m;
            end else begin
                r = r >> 1;
            end
            bit_m = bit_m >> 2;
        end
        return r;
    endfunction

    // 2^(2^-(i+1)) in Q2.30, built by repeated square roots from 2.0.
    function automatic logic [63:0] sbx_root(input int i);
        logic [63:0] c;
        c = 64'd1 << 31;
        for (int j = 0; j < POW_STEPS; j++) begin
            if (j <= i) begin
                c = sbx_isqrt(c << 30);
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/sbx_spread.sv -----
// ============================================================================
// sbx_spread: pipelined SBX spread factor
// Computes beta from the spread draw and distribution index through a log2
// squaring chain, a restoring divider and a root-product power of two.
// ============================================================================
`default_nettype none

module sbx_spread
    import sbx_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [DRAW_W-1:0] u,
    input  wire logic [7:0]        n,
    input  wire gene_side_t        side_in,
    output logic                   out_valid,
    output logic [BETA_W-1:0]      beta,
    output gene_side_t             side_out
);

    localparam int ST_M = LOG_STEPS + 1;
    localparam int ST_G = ST_M + DIV_STEPS + 1;
    localparam int ST_B = ST_G + POW_STEPS + 1;

    logic     [SPR_LAT-1:0] vld_reg;
    spr_ctl_t               ctl_reg [SPR_LAT];

    // Valid bits and control travel alongside the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[SPR_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg[0] <= '{neg: ~u[DRAW_W-1], zero: (u == '0), side: side_in};
            for (int i = 1; i < SPR_LAT; i++) begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    // Range reduction: fold u at or above one half onto 1 - u and normalize.
    logic [15:0] v0;
    logic [3:0]  k0;
    logic [30:0] x0;

    always_comb begin
        v0 = u[DRAW_W-1] ? 16'(17'h10000 - {1'b0, u}) : u;
        k0 = 4'd0;
        for (int i = 1; i < 16; i++) begin
            if (v0[i]) begin
                k0 = 4'(i);
            end
        end
        x0 = 31'({15'd0, v0} << (5'd30 - {1'b0, k0}));
    end

    logic [30:0] lx_reg [LOG_STEPS+1];
    logic [15:0] lf_reg [LOG_STEPS+1];
    logic [3:0]  lk_reg [LOG_STEPS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            lx_reg[0] <= x0;
            lf_reg[0] <= '0;
            lk_reg[0] <= k0;
        end
    end

    // One squaring per stage yields one fraction bit of log2.
    for (genvar i = 1; i <= LOG_STEPS; i++) begin : g_log
        logic [61:0] sq;
        logic [31:0] t;
        assign sq = {31'd0, lx_reg[i-1]} * {31'd0, lx_reg[i-1]};
        assign t  = sq[61:30];
        always_ff @(posedge aclk) begin
            if (en) begin
                lx_reg[i] <= t[31] ? t[31:1] : t[30:0];
                lf_reg[i] <= {lf_reg[i-1][14:0], t[31]};
                lk_reg[i] <= lk_reg[i-1];
            end
        end
    end

    logic [19:0] dm_reg [DIV_STEPS+1];
    logic [8:0]  dr_reg [DIV_STEPS+1];
    logic [19:0] dq_reg [DIV_STEPS+1];
    logic [8:0]  divisor;

    assign divisor = {1'b0, n} + 9'd1;

    always_ff @(posedge aclk) begin
        if (en) begin
            dm_reg[0] <= 20'(15 << 16) - {lk_reg[LOG_STEPS], lf_reg[LOG_STEPS]};
            dr_reg[0] <= '0;
            dq_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        logic [9:0] rt;
        logic       take;
        assign rt   = {dr_reg[j], dm_reg[j][DIV_STEPS-1-j]};
        assign take = (rt >= {1'b0, divisor});
        always_ff @(posedge aclk) begin
            if (en) begin
                dm_reg[j+1] <= dm_reg[j];
                dr_reg[j+1] <= take ? 9'(rt - {1'b0, divisor}) : rt[8:0];
                dq_reg[j+1] <= {dq_reg[j][18:0], take};
            end
        end
    end

    // Negative exponents use 2^(1-f); a zero fraction is a pure shift.
    logic [15:0] ef;
    logic [15:0] g0;
    assign ef = dq_reg[DIV_STEPS][15:0];
    assign g0 = ctl_reg[ST_M + DIV_STEPS].neg
              ? ((ef == '0) ? 16'd0 : 16'(17'h10000 - {1'b0, ef})) : ef;

    logic [30:0] pp_reg  [POW_STEPS+1];
    logic [15:0] pg_reg  [POW_STEPS+1];
    logic [3:0]  pq_reg  [POW_STEPS+1];
    logic        pf0_reg [POW_STEPS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_reg[0]  <= 31'd1 << 30;
            pg_reg[0]  <= g0;
            pq_reg[0]  <= dq_reg[DIV_STEPS][19:16];
            pf0_reg[0] <= (ef == '0);
        end
    end

    for (genvar i = 0; i < POW_STEPS; i++) begin : g_pow
        localparam logic [30:0] ROOT = 31'(sbx_root(i));
        logic [61:0] prod;
        assign prod = {31'd0, pp_reg[i]} * {31'd0, ROOT};
        always_ff @(posedge aclk) begin
            if (en) begin
                pp_reg[i+1]  <= pg_reg[i][POW_STEPS-1-i] ? prod[60:30] : pp_reg[i];
                pg_reg[i+1]  <= pg_reg[i];
                pq_reg[i+1]  <= pq_reg[i];
                pf0_reg[i+1] <= pf0_reg[i];
            end
        end
    end

    logic [63:0]       w;
    logic [BETA_W-1:0] beta_next;
    logic [BETA_W-1:0] beta_reg;
    logic [3:0]        qf;
    spr_ctl_t          cb;

    always_comb begin
        qf = pq_reg[POW_STEPS];
        cb = ctl_reg[ST_B - 1];
        if (!cb.neg) begin
            w = ({33'd0, pp_reg[POW_STEPS]} << qf) >> 14;
        end else if (pf0_reg[POW_STEPS]) begin
            w = (64'd1 << 30) >> ({1'b0, qf} + 5'd14);
        end else begin
            w = {33'd0, pp_reg[POW_STEPS]} >> ({1'b0, qf} + 5'd15);
        end
        if (cb.zero) begin
            beta_next = '0;
        end else if (w > {32'd0, BETA_MAX}) begin
            beta_next = BETA_MAX;
        end else begin
            beta_next = w[BETA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            beta_reg <= beta_next;
        end
    end

    assign out_valid = vld_reg[ST_B];
    assign beta      = beta_reg;
    assign side_out  = ctl_reg[ST_B].side;

endmodule

`default_nettype wire

// ----- src/sbx_gene_crossover.sv -----
// ============================================================================
// sbx_gene_crossover: simulated binary crossover of one gene per item
// Streams gene items through a spread-factor pipeline and a blend stage.
// ============================================================================
// Usage:
//   s_ channel: one item per gene, tdata packs parent_a_gene, parent_b_gene,
//   lower_bound, upper_bound, cross_draw and spread_draw.
//   m_ channel: tdata packs child_a_gene and child_b_gene, tuser is crossed.
//   cfg channel: cfg_index 0 is the distribution index, 1 the crossover
//   probability; cfg_ready is always high. Write only while the block is idle.
// Pipeline:
//   A result passes through 56 stages of the spread unit
//   (16 log2 squarings, 20 divide steps, 16 root multiplies and
//   framing stages) and three blend stages (split multiply, sum, clamp).
//   One item is accepted per cycle while the output is taken or empty.
// Reset and stall:
//   Reset empties the pipeline and loads the register reset values. When the
//   receiver holds m_tready low with a result waiting, the whole pipeline
//   freezes and s_tready drops; nothing is lost or repeated.
// ============================================================================
`default_nettype none

module sbx_gene_crossover
    import sbx_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // parent_a_gene, parent_b_gene, lower_bound, upper_bound, cross_draw, spread_draw
    input  wire logic [159:0]         s_tdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // child_a_gene, child_b_gene
    output logic [63:0]               m_tdata,
    // crossed
    output logic                      m_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    logic [7:0]  dist_index_reg;
    logic [16:0] cross_prob_reg;
    logic        en;

    assign cfg_ready = 1'b1;
    assign en        = m_tready | ~m_tvalid;
    assign s_tready  = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_index_reg <= DIST_INDEX_RESET;
            cross_prob_reg <= CROSS_PROB_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DIST_INDEX: dist_index_reg <= cfg_data[7:0];
                CFG_CROSS_PROB: cross_prob_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    gene_side_t side_in;
    assign side_in = '{
        a:       s_tdata[31:0],
        b:       s_tdata[63:32],
        lo:      s_tdata[95:64],
        hi:      s_tdata[127:96],
        crossed: ({1'b0, s_tdata[143:128]} < cross_prob_reg)
    };

    logic              sp_valid;
    logic [BETA_W-1:0] sp_beta;
    gene_side_t        sp_side;

    sbx_spread u_spread (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .u        (s_tdata[159:144]),
        .n        (dist_index_reg),
        .side_in  (side_in),
        .out_valid(sp_valid),
        .beta     (sp_beta),
        .side_out (sp_side)
    );

    // Blend stage 1: sum, difference and the product split in two halves.
    logic signed [32:0] s1;
    logic signed [32:0] d1;
    logic        [32:0] mag1;
    assign s1   = {sp_side.a[31], sp_side.a} + {sp_side.b[31], sp_side.b};
    assign d1   = {sp_side.a[31], sp_side.a} - {sp_side.b[31], sp_side.b};
    assign mag1 = d1[32] ? 33'(-d1) : d1;

    logic [2:0]         vld_reg;
    gene_side_t         t1_side_reg, t2_side_reg, t3_side_reg;
    logic signed [32:0] t1_s_reg, t2_s_reg;
    logic               t1_neg_reg;
    logic [47:0]        t1_lo_reg;
    logic [48:0]        t1_hi_reg;
    logic signed [48:0] t2_ph_reg;
    gene_t              t3_ca_reg, t3_cb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], sp_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_side_reg <= sp_side;
            t1_s_reg    <= s1;
            t1_neg_reg  <= d1[32];
            t1_lo_reg   <= {32'd0, mag1[15:0]} * {16'd0, sp_beta};
            t1_hi_reg   <= {32'd0, mag1[32:16]} * {17'd0, sp_beta};
        end
    end

    // Blend stage 2: the scaled difference, rounded toward minus infinity.
    logic [63:0]        prod2;
    logic [47:0]        hmag2;
    logic signed [48:0] ph2;
    always_comb begin
        prod2 = 64'({t1_hi_reg, 16'd0}) + {16'd0, t1_lo_reg};
        hmag2 = t1_neg_reg ? 48'((prod2 + 64'hFFFF) >> 16) : 48'(prod2 >> 16);
        ph2   = t1_neg_reg ? -$signed({1'b0, hmag2}) : $signed({1'b0, hmag2});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t2_side_reg <= t1_side_reg;
            t2_s_reg    <= t1_s_reg;
            t2_ph_reg   <= ph2;
        end
    end

    // Blend stage 3: halve, clamp low then high, or pass the parents.
    function automatic gene_t clamp_half(input logic signed [49:0] x, input gene_t lo,
                                         input gene_t hi);
        logic signed [49:0] h;
        logic signed [49:0] lo_e;
        logic signed [49:0] hi_e;
        h    = x >>> 1;
        lo_e = {{18{lo[31]}}, lo};
        hi_e = {{18{hi[31]}}, hi};
        if (h < lo_e) begin
            h = lo_e;
        end
        if (h > hi_e) begin
            h = hi_e;
        end
        return h[31:0];
    endfunction

    logic signed [49:0] sum_a3, sum_b3;
    assign sum_a3 = {{17{t2_s_reg[32]}}, t2_s_reg} + {t2_ph_reg[48], t2_ph_reg};
    assign sum_b3 = {{17{t2_s_reg[32]}}, t2_s_reg} - {t2_ph_reg[48], t2_ph_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            t3_side_reg <= t2_side_reg;
            t3_ca_reg   <= t2_side_reg.crossed
                         ? clamp_half(sum_a3, t2_side_reg.lo, t2_side_reg.hi) : t2_side_reg.a;
            t3_cb_reg   <= t2_side_reg.crossed
                         ? clamp_half(sum_b3, t2_side_reg.lo, t2_side_reg.hi) : t2_side_reg.b;
        end
    end

    assign m_tvalid = vld_reg[2];
    assign m_tdata  = {t3_cb_reg, t3_ca_reg};
    assign m_tuser  = t3_side_reg.crossed;

    // A crossed child with ordered bounds lies within them.
    a_child_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && t3_side_reg.crossed && (t3_side_reg.lo <= t3_side_reg.hi)) |->
        ((t3_ca_reg >= t3_side_reg.lo) && (t3_ca_reg <= t3_side_reg.hi) &&
         (t3_cb_reg >= t3_side_reg.lo) && (t3_cb_reg <= t3_side_reg.hi)))
        else $error("crossed child outside its bounds");

    // Copied parents come out untouched.
    a_copy_parents: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !t3_side_reg.crossed) |->
        ((t3_ca_reg == t3_side_reg.a) && (t3_cb_reg == t3_side_reg.b)))
        else $error("uncrossed item altered");

    // The spread factor never exceeds its cap.
    a_beta_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_valid |-> (sp_beta <= BETA_MAX))
        else $error("spread factor above cap");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: stream test of the SBX gene crossover block
// Drives gene items through the input stream with random gaps and checks every
// result against a directed expectation or a bit-exact fixed-point model of the
// crossover, over several settings of the distribution index and crossover probability.
// ----------------------------------------------------------------------------
module tb_top;
    import sbx_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_PER_PHASE = 100;
    localparam int NUM_PHASES = 6;

    typedef struct packed {
        gene_t       a;
        gene_t       b;
        gene_t       lo;
        gene_t       hi;
        logic [15:0] cross_draw;
        logic [15:0] spread_draw;
    } gene_item_t;

    typedef struct packed {
        gene_t child_a;
        gene_t child_b;
        logic  crossed;
    } child_pair_t;

    typedef struct packed {
        gene_item_t  item;
        logic        typed;
        child_pair_t want;
    } directed_row_t;

    logic           aclk;
    logic           aresetn;
    logic [159:0]   s_tdata;
    logic           s_tvalid;
    logic           s_tready;
    logic [63:0]    m_tdata;
    logic           m_tuser;
    logic           m_tvalid;
    logic           m_tready;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    logic [7:0]     dist_index;
    logic [16:0]    cross_prob;
    child_pair_t    pending_children[$];
    int             error_count;
    int             cycle_count;
    int             sink_hold_cycles;

    sbx_gene_crossover i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------- fixed-point crossover model ----------------

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r, bm, x;
        r  = 0;
        bm = 64'd1 << 62;
        x  = v;
        while (bm > x) bm = bm >> 2;
        while (bm != 0) begin
            if (x >= r + bm) begin
                x = x - (r + bm);
                r = (r >> 1) + bm;
            end else begin
                r = r >> 1;
            end
            bm = bm >> 2;
        end
        return r;
    endfunction

    // 2^(f/65536) in Q2.30.
    function automatic longint unsigned frac_pow2(input longint unsigned f);
        longint unsigned p, c;
        p = 64'd1 << 30;
        c = 64'd1 << 31;
        for (int i = 0; i < 16; i++) begin
            c = root_floor(c << 30);
            if (f[15-i]) p = (p * c) >> 30;
        end
        return p;
    endfunction

    // log2 in Q.16 of v in 1..32768.
    function automatic longint unsigned log2_fix(input longint unsigned v);
        int k;
        longint unsigned x, frac;
        k    = 15;
        frac = 0;
        while (k > 0 && !v[k]) k--;
        x = v << (30 - k);
        for (int i = 0; i < 16; i++) begin
            x = (x * x) >> 30;
            frac = frac << 1;
            if (x >= (64'd1 << 31)) begin
                x = x >> 1;
                frac = frac | 1;
            end
        end
        return (longint'(k) << 16) | frac;
    endfunction

    function automatic longint unsigned spread_factor(input logic [15:0] u, input logic [7:0] n);
        longint unsigned m, e, q, f, b;
        if (u == 0) return 0;
        if (u < 16'd32768) m = (64'd15 << 16) - log2_fix(u);
        else               m = (64'd15 << 16) - log2_fix(64'd65536 - u);
        e = m / (longint'(n) + 1);
        q = e >> 16;
        f = e & 64'hFFFF;
        if (u >= 16'd32768)  b = (frac_pow2(f) << q) >> 14;
        else if (f == 0)     b = (64'd1 << 30) >> (q + 14);
        else                 b = frac_pow2(64'd65536 - f) >> (q + 15);
        if (b > BETA_MAX) b = BETA_MAX;
        return b;
    endfunction

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    function automatic child_pair_t crossover_predict(input gene_item_t it);
        child_pair_t     r;
        longint          a, b, s, d, ph;
        longint unsigned beta, mag, prod;
        a = it.a;
        b = it.b;
        r.child_a = it.a;
        r.child_b = it.b;
        r.crossed = 1'b0;
        if ({1'b0, it.cross_draw} < cross_prob) begin
            beta = spread_factor(it.spread_draw, dist_index);
            s    = a + b;
            d    = a - b;
            mag  = (d < 0) ? -d : d;
            prod = mag * beta;
            if (d < 0) ph = -longint'((prod + 64'hFFFF) >> 16);
            else       ph = longint'(prod >> 16);
            r.child_a = gene_t'(clamp_to((s + ph) >>> 1, it.lo, it.hi));
            r.child_b = gene_t'(clamp_to((s - ph) >>> 1, it.lo, it.hi));
            r.crossed = 1'b1;
        end
        return r;
    endfunction

    // ---------------- stimulus and checking ----------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [16:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_DIST_INDEX) dist_index = val[7:0];
        else if (idx == CFG_CROSS_PROB) cross_prob = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        while (pending_children.size() != 0) @(negedge aclk);
        repeat (70) @(negedge aclk);
    endtask

    // Called at a falling edge, returns at a falling edge.
    task automatic send_gene(input gene_item_t it, input logic typed, input child_pair_t want);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        // The first field sits in the lowest bits of tdata.
        s_tdata  <= {it.spread_draw, it.cross_draw, it.hi, it.lo, it.b, it.a};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_children.push_back(typed ? want : crossover_predict(it));
        @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_draw();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'd32767;
            3: return 16'd32768;
            4: return 16'd65535;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic gene_item_t random_gene();
        gene_item_t it;
        gene_t      x, y;
        it.a = gene_t'($urandom);
        it.b = gene_t'($urandom);
        if ($urandom_range(0, 2) == 0) begin
            // Parents close together, as in a converged population.
            it.b = it.a + gene_t'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
        end
        x = gene_t'($urandom);
        y = gene_t'($urandom);
        case ($urandom_range(0, 3))
            0: begin
                it.lo = 32'sh8000_0000;
                it.hi = 32'sh7FFF_FFFF;
            end
            1: begin
                it.lo = (x < y) ? y : x;
                it.hi = (x < y) ? x : y;
            end
            default: begin
                it.lo = (x < y) ? x : y;
                it.hi = (x < y) ? y : x;
            end
        endcase
        it.cross_draw  = pick_draw();
        it.spread_draw = pick_draw();
        return it;
    endfunction

    always begin
        int gap;
        m_tready <= 1'b0;
        @(negedge aclk);
        while (!aresetn) @(negedge aclk);
        forever begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (sink_hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (sink_hold_cycles) @(negedge aclk);
                sink_hold_cycles = 0;
            end else if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            if (pending_children.size() == 0) begin
                $display("unexpected result %h at cycle %0d", m_tdata, cycle_count);
                error_count++;
            end else begin
                child_pair_t want;
                want = pending_children.pop_front();
                if (m_tdata[31:0] !== want.child_a)
                    report_mismatch("child_a_gene", m_tdata[31:0], want.child_a);
                if (m_tdata[63:32] !== want.child_b)
                    report_mismatch("child_b_gene", m_tdata[63:32], want.child_b);
                if (m_tuser !== want.crossed)
                    report_mismatch("crossed", {31'd0, m_tuser}, {31'd0, want.crossed});
            end
            @(negedge aclk);
        end
    end

    directed_row_t directed_rows[] = '{
        // No crossover: draw at or above the probability copies the parents.
        '{'{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'sh0, 16'd65535, 16'd0},
          1'b1, '{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0}},
        '{'{32'sh0001_0000, 32'sh0005_0000, 32'sh0, 32'sh0, 16'd32768, 16'd12345},
          1'b1, '{32'sh0001_0000, 32'sh0005_0000, 1'b0}},
        // Zero spread draw gives the mean of the parents.
        '{'{32'sh0002_0000, 32'sh0004_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'd0, 16'd0},
          1'b1, '{32'sh0003_0000, 32'sh0003_0000, 1'b1}},
        '{'{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'd0, 16'd0},
          1'b1, '{32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b1}},
        // Crossed bounds: the upper bound wins; then a clamp to each ordered bound.
        '{'{32'sh0, 32'sh0, 32'sh0001_0000, 32'shFFFF_0000, 16'd0, 16'd0},
          1'b1, '{32'shFFFF_0000, 32'shFFFF_0000, 1'b1}},
        '{'{32'sh0005_0000, 32'sh0005_0000, 32'sh0, 32'sh0001_0000, 16'd0, 16'd0},
          1'b1, '{32'sh0001_0000, 32'sh0001_0000, 1'b1}},
        '{'{32'shFFFB_0000, 32'shFFFB_0000, 32'shFFFF_0000, 32'sh0001_0000, 16'd0, 16'd0},
          1'b1, '{32'shFFFF_0000, 32'shFFFF_0000, 1'b1}},
        // Spread draw extremes, checked against the model.
        '{'{32'sh0001_0000, 32'shFFFF_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'd0, 16'd1},
          1'b0, '0},
        '{'{32'sh0001_0000, 32'shFFFF_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'd0, 16'd32767},
          1'b0, '0},
        '{'{32'sh0001_0000, 32'shFFFF_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'd0, 16'd32768},
          1'b0, '0},
        '{'{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'd1, 16'd65535},
          1'b0, '0},
        '{'{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'd32767, 16'd65535},
          1'b0, '0},
        '{'{32'shFFFF_FFFF, 32'sh0000_0001, 32'shFFFF_FFFE, 32'sh0000_0002, 16'd100, 16'd40000},
          1'b0, '0}
    };

    logic [7:0]  phase_index[NUM_PHASES] = '{8'd0, 8'd255, 8'd1, 8'd20, 8'd7, 8'd20};
    logic [16:0] phase_prob[NUM_PHASES]  = '{17'd65536, 17'd65536, 17'd0, 17'd40000,
                                              17'd131071, 17'd32768};

    initial begin
        aresetn          = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        error_count      = 0;
        cycle_count      = 0;
        sink_hold_cycles = 0;
        dist_index       = DIST_INDEX_RESET;
        cross_prob       = CROSS_PROB_RESET;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i])
            send_gene(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        s_tvalid <= 1'b0;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            logic [7:0]  n_val;
            logic [16:0] p_val;
            n_val = phase_index[ph];
            p_val = phase_prob[ph];
            if (ph == 3) begin
                n_val = 8'($urandom);
                p_val = 17'($urandom_range(0, 65536));
            end
            wait_idle();
            write_register(CFG_DIST_INDEX, {9'd0, n_val});
            write_register(CFG_CROSS_PROB, p_val);
            // An index past the register list must leave both registers alone.
            if (ph == 0)
                write_register(CFG_IDX_W'(CFG_CROSS_PROB + 8'd1), 17'($urandom));
            if (ph == 1) sink_hold_cycles = 400;
            for (int k = 0; k < RANDOM_PER_PHASE; k++)
                send_gene(random_gene(), 1'b0, '0);
            s_tvalid <= 1'b0;
        end

        while (pending_children.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (pending_children.size() != 0) error_count++;
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
